/* src/dtq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared constants and types for the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int TIME_BITS_DEF = 56;

    localparam logic [31:0] RES_RESET  = 32'd20000000;
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    // request operation codes
    localparam logic [1:0] OP_SCHED  = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_FIRE   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SCHED  = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_DISP   = 2'd2;
    localparam logic [1:0] KIND_ALARM  = 2'd3;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOTPEND = 2'd2;

    // register index
    localparam logic REG_RESOLUTION = 1'b0;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // open a gap at the sort position and load the new entry
        logic del;   // close the gap at pos, pull from the right neighbor
    } cell_ctl_t;

endpackage

`default_nettype wire

/* src/dtq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_cell
// One queue position: holds one entry and trades it with its neighbors.
// ----------------------------------------------------------------------------
module dtq_cell
    import dtq_pkg::*;
#(
    parameter int TB  = TIME_BITS_DEF,
    parameter int SW  = 5,
    parameter int IDX = 0
)
(
    input  wire logic          clk,
    input  wire cell_ctl_t     ctl,
    input  wire logic [SW-1:0] pos,
    input  wire logic          live,
    input  wire logic [TB-1:0] new_time,
    input  wire logic [31:0]   new_tag,
    input  wire logic [SW-1:0] new_slot,
    input  wire logic          left_gt,
    input  wire logic [TB-1:0] left_time,
    input  wire logic [31:0]   left_tag,
    input  wire logic [SW-1:0] left_slot,
    input  wire logic [TB-1:0] right_time,
    input  wire logic [31:0]   right_tag,
    input  wire logic [SW-1:0] right_slot,
    output logic               gt,
    output logic [TB-1:0]      cur_time,
    output logic [31:0]        cur_tag,
    output logic [SW-1:0]      cur_slot
);

    logic [TB-1:0] time_reg, time_next;
    logic [31:0]   tag_reg, tag_next;
    logic [SW-1:0] slot_reg, slot_next;

    // empty positions count as later than anything
    assign gt = !live || (time_reg > new_time);

    always_comb
    begin
        time_next = time_reg;
        tag_next  = tag_reg;
        slot_next = slot_reg;
        if (ctl.ins && gt)
        begin
            if (!left_gt)
            begin
                time_next = new_time;
                tag_next  = new_tag;
                slot_next = new_slot;
            end
            else
            begin
                time_next = left_time;
                tag_next  = left_tag;
                slot_next = left_slot;
            end
        end
        else if (ctl.del && (SW'(IDX) >= pos))
        begin
            time_next = right_time;
            tag_next  = right_tag;
            slot_next = right_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        tag_reg  <= tag_next;
        slot_reg <= slot_next;
    end

    assign cur_time = time_reg;
    assign cur_tag  = tag_reg;
    assign cur_slot = slot_reg;

endmodule

`default_nettype wire

/* src/deadline_timer_queue_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_timer_queue_top
// Software timer queue: pending tasks kept sorted by absolute firing time.
// ----------------------------------------------------------------------------
// The queue is a row of DEPTH cells, cell 0 holding the earliest task; a
// schedule opens a gap at the sort position, a cancel or a dispatched task
// closes one. One request is worked at a time and input stall stays high
// until its last result has been loaded into the output register. A schedule
// finds the lowest free slot, forms the deadline and inserts, then reports an
// alarm update when the new task becomes the head; a cancel finds the queue
// position and deletes, with an alarm update when the head was removed; a fire
// scans the batch window, dispatches in reverse order and removes one head per
// step, then reports the alarm. The free slot and cancel lookups walk one
// entry per cycle, and so do the three fire phases, the dispatch phase only
// while the output side takes results. Failed requests give a single result.
// No clearing pass after reset. resolution_ns sits at byte address 0 of the
// APB port.
// ----------------------------------------------------------------------------
module deadline_timer_queue_top
    import dtq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // requests
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [55:0] now_ns,
    input  wire logic [30:0] delay_seconds,
    input  wire logic [55:0] delay_nanoseconds,
    input  wire logic [31:0] task_tag,
    input  wire logic [4:0]  cancel_handle,
    input  wire logic [31:0] lateness_ns,
    // results
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [1:0]  kind,
    output logic      [1:0]  status,
    output logic      [4:0]  handle,
    output logic      [31:0] dispatch_tag,
    output logic             alarm_update,
    output logic             alarm_on,
    output logic      [55:0] alarm_interval_ns,
    output logic             last
);

    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TB = TIME_BITS;
    localparam logic [64:0] TMAX = 65'((65'(1) << TB) - 65'(1));

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_FIND  = 14'b00000000000010,
        S_MUL   = 14'b00000000000100,
        S_SUM1  = 14'b00000000001000,
        S_SUM2  = 14'b00000000010000,
        S_INS   = 14'b00000000100000,
        S_CSRCH = 14'b00000001000000,
        S_CDEL  = 14'b00000010000000,
        S_BATCH = 14'b00000100000000,
        S_DISP  = 14'b00001000000000,
        S_DROP  = 14'b00010000000000,
        S_ALM1  = 14'b00100000000000,
        S_ALM2  = 14'b01000000000000,
        S_ONE   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // control state
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    take_reg, take_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [31:0]      res_reg, res_next;
    logic             o_vld_reg, o_vld_next;

    // request payload and working values
    logic [TB-1:0] now_reg, now_next;
    logic [30:0]   secs_reg, secs_next;
    logic [55:0]   nsec_reg, nsec_next;
    logic [31:0]   tag_reg, tag_next;
    logic [4:0]    ch_reg, ch_next;
    logic [31:0]   late_reg, late_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [60:0]   prod_reg, prod_next;
    logic [TB-1:0] acc_reg, acc_next;
    logic [TB-1:0] diff_reg, diff_next;
    logic [1:0]    r_kind_reg, r_kind_next;
    logic [1:0]    r_status_reg, r_status_next;
    logic [4:0]    r_handle_reg, r_handle_next;

    // output register
    logic [1:0]  o_kind_reg, o_kind_next;
    logic [1:0]  o_status_reg, o_status_next;
    logic [4:0]  o_handle_reg, o_handle_next;
    logic [31:0] o_tag_reg, o_tag_next;
    logic        o_upd_reg, o_upd_next;
    logic        o_on_reg, o_on_next;
    logic [55:0] o_ival_reg, o_ival_next;
    logic        o_last_reg, o_last_next;

    // cell chain
    cell_ctl_t     ctl;
    logic [SW-1:0] pos;
    logic [TB-1:0] c_time [DEPTH];
    logic [31:0]   c_tag  [DEPTH];
    logic [SW-1:0] c_slot [DEPTH];
    logic          c_gt   [DEPTH];

    logic          in_acc, emit_ok, cfg_wr;
    logic [SW-1:0] rd_i, chi, in_chi;
    logic [64:0]   now_w, sum_w;
    logic [TB-1:0] iv;
    logic          head_new;

    assign in_acc  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign emit_ok = !o_vld_reg || !out_stall;
    assign rd_i    = idx_reg[SW-1:0];
    assign chi     = SW'(ch_reg);
    assign in_chi  = SW'(cancel_handle);

    // APB: one register, always ready
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_RESOLUTION) ? res_reg : 32'd0;
    assign res_next = (cfg_wr && paddr[2] == REG_RESOLUTION) ? pwdata : res_reg;

    // clamp time into the stored range
    assign now_w = 65'(now_ns);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            dtq_cell #(
                .TB  (TB),
                .SW  (SW),
                .IDX (gi)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .pos        (pos),
                .live       (count_reg > CW'(gi)),
                .new_time   (acc_reg),
                .new_tag    (tag_reg),
                .new_slot   (slot_reg),
                .left_gt    ((gi == 0) ? 1'b0 : c_gt[(gi == 0) ? 0 : gi - 1]),
                .left_time  (c_time[(gi == 0) ? 0 : gi - 1]),
                .left_tag   (c_tag[(gi == 0) ? 0 : gi - 1]),
                .left_slot  (c_slot[(gi == 0) ? 0 : gi - 1]),
                .right_time (c_time[(gi == DEPTH - 1) ? gi : gi + 1]),
                .right_tag  (c_tag[(gi == DEPTH - 1) ? gi : gi + 1]),
                .right_slot (c_slot[(gi == DEPTH - 1) ? gi : gi + 1]),
                .gt         (c_gt[gi]),
                .cur_time   (c_time[gi]),
                .cur_tag    (c_tag[gi]),
                .cur_slot   (c_slot[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        take_next     = take_reg;
        valid_next    = valid_reg;
        now_next      = now_reg;
        secs_next     = secs_reg;
        nsec_next     = nsec_reg;
        tag_next      = tag_reg;
        ch_next       = ch_reg;
        late_next     = late_reg;
        slot_next     = slot_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        diff_next     = diff_reg;
        r_kind_next   = r_kind_reg;
        r_status_next = r_status_reg;
        r_handle_next = r_handle_reg;
        ctl           = '0;
        pos           = '0;
        sum_w         = '0;
        iv            = '0;
        head_new      = (count_reg == '0) || (acc_reg < c_time[0]);

        // drop the held result once it is taken
        o_vld_next    = o_vld_reg && out_stall;
        o_kind_next   = o_kind_reg;
        o_status_next = o_status_reg;
        o_handle_next = o_handle_reg;
        o_tag_next    = o_tag_reg;
        o_upd_next    = o_upd_reg;
        o_on_next     = o_on_reg;
        o_ival_next   = o_ival_reg;
        o_last_next   = o_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    now_next  = (now_w > TMAX) ? TMAX[TB-1:0] : now_w[TB-1:0];
                    secs_next = delay_seconds;
                    nsec_next = delay_nanoseconds;
                    tag_next  = task_tag;
                    ch_next   = cancel_handle;
                    late_next = (operation == OP_FIRE) ? lateness_ns : 32'd0;
                    idx_next  = '0;
                    r_kind_next   = KIND_ALARM;
                    r_status_next = ST_OK;
                    r_handle_next = '0;
                    unique case (operation)
                        OP_SCHED:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                r_kind_next   = KIND_SCHED;
                                r_status_next = ST_FULL;
                                state_next    = S_ONE;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        OP_CANCEL:
                        begin
                            if (32'(cancel_handle) >= 32'(DEPTH) || !valid_reg[in_chi])
                            begin
                                r_kind_next   = KIND_CANCEL;
                                r_status_next = ST_NOTPEND;
                                r_handle_next = cancel_handle;
                                state_next    = S_ONE;
                            end
                            else
                            begin
                                state_next = S_CSRCH;
                            end
                        end
                        OP_FIRE:
                        begin
                            state_next = (count_reg == '0) ? S_ONE : S_BATCH;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FIND:
            begin
                // walk to the lowest free slot; one exists below DEPTH
                if (!valid_reg[rd_i])
                begin
                    slot_next  = rd_i;
                    state_next = S_MUL;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_MUL:
            begin
                prod_next  = secs_reg * NS_PER_SEC;
                state_next = S_SUM1;
            end

            S_SUM1:
            begin
                sum_w      = 65'(now_reg) + 65'(prod_reg);
                acc_next   = (sum_w > TMAX) ? TMAX[TB-1:0] : sum_w[TB-1:0];
                state_next = S_SUM2;
            end

            S_SUM2:
            begin
                sum_w      = 65'(acc_reg) + 65'(nsec_reg);
                acc_next   = (sum_w > TMAX) ? TMAX[TB-1:0] : sum_w[TB-1:0];
                state_next = S_INS;
            end

            S_INS:
            begin
                if (emit_ok)
                begin
                    ctl.ins               = 1'b1;
                    count_next            = count_reg + CW'(1);
                    valid_next[slot_reg]  = 1'b1;
                    o_vld_next    = 1'b1;
                    o_kind_next   = KIND_SCHED;
                    o_status_next = ST_OK;
                    o_handle_next = 5'(slot_reg);
                    o_tag_next    = '0;
                    o_upd_next    = 1'b0;
                    o_on_next     = 1'b0;
                    o_ival_next   = '0;
                    o_last_next   = !head_new;
                    state_next    = head_new ? S_ALM1 : S_IDLE;
                end
            end

            S_CSRCH:
            begin
                // the handle is pending, so the walk always hits
                if (c_slot[rd_i] == chi)
                begin
                    state_next = S_CDEL;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            S_CDEL:
            begin
                if (emit_ok)
                begin
                    ctl.del          = 1'b1;
                    pos              = rd_i;
                    count_next       = count_reg - CW'(1);
                    valid_next[chi]  = 1'b0;
                    o_vld_next    = 1'b1;
                    o_kind_next   = KIND_CANCEL;
                    o_status_next = ST_OK;
                    o_handle_next = ch_reg;
                    o_tag_next    = '0;
                    o_upd_next    = 1'b0;
                    o_on_next     = 1'b0;
                    o_ival_next   = '0;
                    o_last_next   = (idx_reg != '0);
                    state_next    = (idx_reg == '0) ? S_ALM1 : S_IDLE;
                end
            end

            S_BATCH:
            begin
                // extend the batch while within resolution of the head
                if (idx_reg < count_reg &&
                    (c_time[rd_i] - c_time[0]) <= TB'(res_reg))
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    take_next  = idx_reg;
                    idx_next   = idx_reg - CW'(1);
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                // dispatch from the batch end back toward the head
                if (emit_ok)
                begin
                    valid_next[c_slot[rd_i]] = 1'b0;
                    o_vld_next    = 1'b1;
                    o_kind_next   = KIND_DISP;
                    o_status_next = ST_OK;
                    o_handle_next = 5'(c_slot[rd_i]);
                    o_tag_next    = c_tag[rd_i];
                    o_upd_next    = 1'b0;
                    o_on_next     = 1'b0;
                    o_ival_next   = '0;
                    o_last_next   = 1'b0;
                    if (idx_reg == '0)
                    begin
                        state_next = S_DROP;
                    end
                    else
                    begin
                        idx_next = idx_reg - CW'(1);
                    end
                end
            end

            S_DROP:
            begin
                // advance the chain by one per dispatched task
                ctl.del    = 1'b1;
                pos        = '0;
                count_next = count_reg - CW'(1);
                take_next  = take_reg - CW'(1);
                if (take_reg == CW'(1))
                begin
                    state_next = S_ALM1;
                end
            end

            S_ALM1:
            begin
                diff_next  = (c_time[0] > now_reg) ? (c_time[0] - now_reg) : '0;
                state_next = S_ALM2;
            end

            S_ALM2:
            begin
                iv = (diff_reg > TB'(late_reg)) ? (diff_reg - TB'(late_reg)) : '0;
                if (iv < TB'(res_reg))
                begin
                    iv = TB'(res_reg);
                end
                if (count_reg == '0)
                begin
                    iv = '0;
                end
                if (emit_ok)
                begin
                    o_vld_next    = 1'b1;
                    o_kind_next   = KIND_ALARM;
                    o_status_next = ST_OK;
                    o_handle_next = '0;
                    o_tag_next    = '0;
                    o_upd_next    = 1'b1;
                    o_on_next     = (count_reg != '0);
                    o_ival_next   = 56'(iv);
                    o_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_ONE:
            begin
                if (emit_ok)
                begin
                    o_vld_next    = 1'b1;
                    o_kind_next   = r_kind_reg;
                    o_status_next = r_status_reg;
                    o_handle_next = r_handle_reg;
                    o_tag_next    = '0;
                    o_upd_next    = 1'b0;
                    o_on_next     = 1'b0;
                    o_ival_next   = '0;
                    o_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            take_reg  <= '0;
            valid_reg <= '0;
            res_reg   <= RES_RESET;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            take_reg  <= take_next;
            valid_reg <= valid_next;
            res_reg   <= res_next;
            o_vld_reg <= o_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        secs_reg     <= secs_next;
        nsec_reg     <= nsec_next;
        tag_reg      <= tag_next;
        ch_reg       <= ch_next;
        late_reg     <= late_next;
        slot_reg     <= slot_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        diff_reg     <= diff_next;
        r_kind_reg   <= r_kind_next;
        r_status_reg <= r_status_next;
        r_handle_reg <= r_handle_next;
        o_kind_reg   <= o_kind_next;
        o_status_reg <= o_status_next;
        o_handle_reg <= o_handle_next;
        o_tag_reg    <= o_tag_next;
        o_upd_reg    <= o_upd_next;
        o_on_reg     <= o_on_next;
        o_ival_reg   <= o_ival_next;
        o_last_reg   <= o_last_next;
    end

    assign out_valid         = o_vld_reg;
    assign kind              = o_kind_reg;
    assign status            = o_status_reg;
    assign handle            = o_handle_reg;
    assign dispatch_tag      = o_tag_reg;
    assign alarm_update      = o_upd_reg;
    assign alarm_on          = o_on_reg;
    assign alarm_interval_ns = o_ival_reg;
    assign last              = o_last_reg;

endmodule

`default_nettype wire

/* bench/tb_deadline_timer_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadline_timer_queue_top
// Self-checking bench for the deadline timer queue.
// ----------------------------------------------------------------------------
// A table of directed requests runs first: reset state, time extremes,
// saturation, queue full, bad cancels, fires on an empty queue and the
// unused operation code. Random requests follow; most of them are schedule
// and fire requests that keep the queue busy, with cancels of live and dead
// handles mixed in. A software copy of the queue predicts every result, and
// the monitor compares each accepted result with the oldest prediction.
// Both sides idle at random; the receiver holds off once for a long stretch
// so that the queue backs up, and the sender drains once before going on.
// resolution_ns is written between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_deadline_timer_queue_top;
    import dtq_pkg::*;

    localparam int          QDEPTH   = 32;
    localparam logic [55:0] TIME_TOP = {56{1'b1}};

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [4:0]  handle;
        logic [31:0] dispatch_tag;
        logic        alarm_update;
        logic        alarm_on;
        logic [55:0] alarm_interval_ns;
        logic        last;
    } timer_result_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [55:0] now_ns;
        logic [30:0] delay_seconds;
        logic [55:0] delay_nanoseconds;
        logic [31:0] task_tag;
        logic [4:0]  cancel_handle;
        logic [31:0] lateness_ns;
    } timer_request_t;

    // one directed row: the request plus, where obvious, its single result
    typedef struct {
        timer_request_t req;
        bit             has_literal;
        timer_result_t  literal;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = '0;
    logic [55:0] now_ns = '0;
    logic [30:0] delay_seconds = '0;
    logic [55:0] delay_nanoseconds = '0;
    logic [31:0] task_tag = '0;
    logic [4:0]  cancel_handle = '0;
    logic [31:0] lateness_ns = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [4:0]  handle;
    logic [31:0] dispatch_tag;
    logic        alarm_update;
    logic        alarm_on;
    logic [55:0] alarm_interval_ns;
    logic        last;

    // shadow queue state
    logic [55:0] slot_deadline [QDEPTH];
    logic [31:0] slot_work     [QDEPTH];
    bit          slot_busy     [QDEPTH];
    logic [4:0]  fire_order    [QDEPTH];
    int          queued;
    logic [31:0] resolution;

    timer_result_t pending_results[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  dispatches_seen = 0;
    int  requests_sent = 0;
    bit  hold_off = 1'b0;   // long receiver hold-off in progress
    bit  hold_req = 1'b0;

    deadline_timer_queue_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .now_ns(now_ns), .delay_seconds(delay_seconds),
        .delay_nanoseconds(delay_nanoseconds), .task_tag(task_tag),
        .cancel_handle(cancel_handle), .lateness_ns(lateness_ns),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
        .status(status), .handle(handle), .dispatch_tag(dispatch_tag),
        .alarm_update(alarm_update), .alarm_on(alarm_on),
        .alarm_interval_ns(alarm_interval_ns), .last(last)
    );

    always #1 clk = ~clk;

    // hard limit: far beyond the slowest legal run
    initial
    begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [55:0] sat_sum(logic [55:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {9'd0, a} + {1'b0, b};
        return (s > {9'd0, TIME_TOP}) ? TIME_TOP : s[55:0];
    endfunction

    function automatic timer_result_t make_result(logic [1:0] k, logic [1:0] st,
            logic [4:0] h, logic [31:0] tg, logic upd, logic on,
            logic [55:0] iv, logic lst);
        timer_result_t r;
        r.kind = k; r.status = st; r.handle = h; r.dispatch_tag = tg;
        r.alarm_update = upd; r.alarm_on = on; r.alarm_interval_ns = iv;
        r.last = lst;
        return r;
    endfunction

    // alarm setting that follows from the current head
    function automatic timer_result_t head_alarm(logic [55:0] now, logic [31:0] late);
        logic [55:0] head, ival;
        ival = '0;
        if (queued == 0)
            return make_result(KIND_ALARM, ST_OK, 0, 0, 1'b1, 1'b0, 0, 1'b1);
        head = slot_deadline[fire_order[0]];
        if (head > now && head - now > {24'd0, late})
            ival = head - now - {24'd0, late};
        if (ival < {24'd0, resolution})
            ival = {24'd0, resolution};
        return make_result(KIND_ALARM, ST_OK, 0, 0, 1'b1, 1'b1, ival, 1'b1);
    endfunction

    // advance the shadow queue by one request and queue up its results
    task automatic predict_queue(timer_request_t rq);
        int          pos, slot, take, i;
        logic [55:0] due, first;
        logic [63:0] secs_ns;
        if (rq.operation == OP_SCHED)
        begin
            slot = -1;
            for (i = QDEPTH - 1; i >= 0; i--)
                if (!slot_busy[i]) slot = i;
            if (queued >= QDEPTH || slot < 0)
            begin
                pending_results.push_back(make_result(KIND_SCHED, ST_FULL, 0, 0, 0, 0, 0, 1));
                return;
            end
            secs_ns = 64'(rq.delay_seconds) * 64'd1000000000;
            due = sat_sum(sat_sum(rq.now_ns, secs_ns), {8'd0, rq.delay_nanoseconds});
            pos = queued;
            for (i = queued - 1; i >= 0; i--)
                if (slot_deadline[fire_order[i]] > due) pos = i;
            for (i = queued; i > pos; i--)
                fire_order[i] = fire_order[i - 1];
            fire_order[pos] = slot[4:0];
            slot_deadline[slot] = due;
            slot_work[slot] = rq.task_tag;
            slot_busy[slot] = 1'b1;
            queued++;
            pending_results.push_back(make_result(KIND_SCHED, ST_OK, slot[4:0], 0, 0, 0, 0,
                                                  pos != 0));
            if (pos == 0)
                pending_results.push_back(head_alarm(rq.now_ns, 0));
        end
        else if (rq.operation == OP_CANCEL)
        begin
            if (!slot_busy[rq.cancel_handle])
            begin
                pending_results.push_back(make_result(KIND_CANCEL, ST_NOTPEND,
                                                      rq.cancel_handle, 0, 0, 0, 0, 1));
                return;
            end
            pos = 0;
            while (fire_order[pos] != rq.cancel_handle) pos++;
            for (i = pos; i + 1 < queued; i++)
                fire_order[i] = fire_order[i + 1];
            queued--;
            slot_busy[rq.cancel_handle] = 1'b0;
            pending_results.push_back(make_result(KIND_CANCEL, ST_OK, rq.cancel_handle,
                                                  0, 0, 0, 0, pos != 0));
            if (pos == 0)
                pending_results.push_back(head_alarm(rq.now_ns, 0));
        end
        else if (rq.operation == OP_FIRE)
        begin
            if (queued == 0)
            begin
                pending_results.push_back(make_result(KIND_ALARM, ST_OK, 0, 0, 0, 0, 0, 1));
                return;
            end
            first = slot_deadline[fire_order[0]];
            take = 0;
            while (take < queued &&
                   slot_deadline[fire_order[take]] - first <= {24'd0, resolution})
                take++;
            // dispatch in reverse order of firing time
            for (i = take; i > 0; i--)
            begin
                slot = int'(fire_order[i - 1]);
                pending_results.push_back(make_result(KIND_DISP, ST_OK, slot[4:0],
                                                      slot_work[slot], 0, 0, 0, 0));
                slot_busy[slot] = 1'b0;
            end
            for (i = take; i < queued; i++)
                fire_order[i - take] = fire_order[i];
            queued -= take;
            pending_results.push_back(head_alarm(rq.now_ns, rq.lateness_ns));
        end
        // operation code 3 is ignored by the block
    endtask

    // ---------------- result monitor and receiver idling ----------------
    always @(posedge clk)
    begin
        timer_result_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = make_result(kind, status, handle, dispatch_tag, alarm_update,
                              alarm_on, alarm_interval_ns, last);
            results_seen++;
            if (got.kind == KIND_DISP) dispatches_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // receiver: random stall per result, or a long hold-off when asked
    initial
    begin
        int waits;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                hold_off = 1'b1;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
                hold_req = 1'b0;
            end
            waits = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (waits > 0)
            begin
                out_stall <= 1'b1;
                repeat (waits) @(negedge clk);
            end
            out_stall <= 1'b0;
            // keep ready until one result goes through
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // ---------------- sender ----------------
    task automatic send_request(timer_request_t rq, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation <= rq.operation;
        now_ns <= rq.now_ns;
        delay_seconds <= rq.delay_seconds;
        delay_nanoseconds <= rq.delay_nanoseconds;
        task_tag <= rq.task_tag;
        cancel_handle <= rq.cancel_handle;
        lateness_ns <= rq.lateness_ns;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        predict_queue(rq);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_resolution(logic [31:0] value);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {REG_RESOLUTION, 2'b00}; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        resolution = value;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic timer_request_t build_request(logic [1:0] op, logic [55:0] now,
            logic [30:0] secs, logic [55:0] nsec, logic [31:0] tg, logic [4:0] ch,
            logic [31:0] late);
        timer_request_t r;
        r.operation = op; r.now_ns = now; r.delay_seconds = secs;
        r.delay_nanoseconds = nsec; r.task_tag = tg; r.cancel_handle = ch;
        r.lateness_ns = late;
        return r;
    endfunction

    function automatic directed_row_t row(timer_request_t rq, bit lit,
                                          timer_result_t res);
        directed_row_t d;
        d.req = rq; d.has_literal = lit; d.literal = res;
        return d;
    endfunction

    // random request: mostly live traffic, some noise
    function automatic timer_request_t random_request(logic [55:0] base);
        timer_request_t r;
        int pick;
        r.now_ns = base + 56'($urandom_range(0, 1000));
        r.delay_seconds = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 2));
        r.delay_nanoseconds = ($urandom_range(0, 9) == 0) ? 56'({$urandom, $urandom}) :
                              56'($urandom_range(0, 60000000));
        r.task_tag = $urandom;
        r.cancel_handle = 5'($urandom_range(0, 31));
        r.lateness_ns = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000000);
        if ($urandom_range(0, 19) == 0)
            r.now_ns = 56'({$urandom, $urandom});
        pick = $urandom_range(0, 19);
        if (pick < 10)      r.operation = OP_SCHED;
        else if (pick < 14) r.operation = OP_CANCEL;
        else if (pick < 19) r.operation = OP_FIRE;
        else                r.operation = 2'd3;
        return r;
    endfunction

    initial
    begin
        directed_row_t  rows[$];
        timer_request_t rq;
        logic [31:0]    res_set[4];
        logic [55:0]    clock_ns;
        int             i, phase, n;
        timer_result_t  lit;

        for (i = 0; i < QDEPTH; i++) slot_busy[i] = 1'b0;
        queued = 0;
        resolution = RES_RESET;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed table ----
        // empty fire after reset: single alarm report, alarm untouched
        rows.push_back(row(build_request(OP_FIRE, 0, 0, 0, 0, 0, 32'hFFFFFFFF), 1,
                           make_result(KIND_ALARM, ST_OK, 0, 0, 0, 0, 0, 1)));
        // cancel of a free slot
        rows.push_back(row(build_request(OP_CANCEL, 0, 0, 0, 0, 5'd31, 0), 1,
                           make_result(KIND_CANCEL, ST_NOTPEND, 5'd31, 0, 0, 0, 0, 1)));
        // unused operation: no result
        rows.push_back(row(build_request(2'd3, TIME_TOP, 31'h7FFFFFFF, TIME_TOP,
                                         32'hFFFFFFFF, 5'd31, 32'hFFFFFFFF), 0, lit));
        // saturating deadlines at the extremes
        rows.push_back(row(build_request(OP_SCHED, TIME_TOP, 31'h7FFFFFFF, TIME_TOP,
                                         32'hFFFFFFFF, 0, 0), 0, lit));
        rows.push_back(row(build_request(OP_SCHED, 0, 0, 0, 32'h0, 0, 0), 0, lit));
        rows.push_back(row(build_request(OP_SCHED, 0, 0, 0, 32'h1, 0, 0), 0, lit));
        rows.push_back(row(build_request(OP_SCHED, 1000, 1, 5, 32'hA5A5A5A5, 0, 0), 0, lit));
        // cancel the head, then a middle entry
        rows.push_back(row(build_request(OP_CANCEL, 0, 0, 0, 0, 5'd1, 0), 0, lit));
        rows.push_back(row(build_request(OP_CANCEL, 0, 0, 0, 0, 5'd3, 0), 0, lit));
        // head already past with big lateness
        rows.push_back(row(build_request(OP_FIRE, 56'd500, 0, 0, 0, 0, 32'hFFFFFFFF), 0, lit));
        rows.push_back(row(build_request(OP_FIRE, TIME_TOP, 0, 0, 0, 0, 0), 0, lit));
        rows.push_back(row(build_request(OP_FIRE, 0, 0, 0, 0, 0, 0), 1,
                           make_result(KIND_ALARM, ST_OK, 0, 0, 0, 0, 0, 1)));
        foreach (rows[r])
        begin
            send_request(rows[r].req, 0);
            // literal rows: check the last result against the typed value
            if (rows[r].has_literal)
                pending_results[pending_results.size() - 1] = rows[r].literal;
        end
        // fill the queue and overflow it once
        for (i = 0; i < QDEPTH + 1; i++)
            send_request(build_request(OP_SCHED, 56'd100, 0, 56'(i * 7), $urandom, 0, 0),
                         $urandom_range(0, 2));
        drain_results();
        // big window: one fire empties the full queue
        write_resolution(32'hFFFFFFFF);
        send_request(build_request(OP_FIRE, 56'd100, 0, 0, 0, 0, 0), 0);
        drain_results();

        // ---- random phases over several resolutions ----
        res_set[0] = 32'd1;
        res_set[1] = RES_RESET;
        res_set[2] = 32'd5000000;
        res_set[3] = 32'hFFFFFFFF;
        clock_ns = 56'd1000000;
        for (phase = 0; phase < 4; phase++)
        begin
            write_resolution(res_set[phase]);
            for (n = 0; n < 28; n++)
            begin
                if (phase == 1 && n == 10) hold_req = 1'b1;
                if (phase == 2 && n == 20) drain_results();
                clock_ns = clock_ns + 56'($urandom_range(0, 30000000));
                rq = random_request(clock_ns);
                send_request(rq, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11));
            end
            drain_results();
        end

        while (hold_off) @(negedge clk);
        drain_results();
        $display("covered %0d requests, %0d results (%0d dispatches), 5 resolution settings",
                 requests_sent, results_seen, dispatches_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
